FILE: hdl/cbor_head_encoder_top_defines.svh
// Assertion macros shared by the encoder modules.
`ifndef CBOR_HEAD_ENCODER_TOP_DEFINES_SVH
`define CBOR_HEAD_ENCODER_TOP_DEFINES_SVH

// Checks a property at every rising edge outside reset.
`define CBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define CBE_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/cbe_pkg.sv
package cbe_pkg;

  typedef enum logic [1:0] {
    ModeHead    = 2'd0,
    ModeSigned  = 2'd1,
    ModePayload = 2'd2,
    ModeClear   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [2:0]  major_type;
    logic [63:0] argument;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [15:0] byte_position;
    logic        overflow;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic        is_clear;
    logic [7:0]  first_byte;
    logic [3:0]  nbytes;
    logic [63:0] arg;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [15:0] CapacityReset = 16'd256;

  localparam logic [2:0] MajorUnsigned = 3'd0;
  localparam logic [2:0] MajorNegative = 3'd1;

  localparam logic [4:0] InfoOneByte   = 5'd24;
  localparam logic [4:0] InfoTwoBytes  = 5'd25;
  localparam logic [4:0] InfoFourBytes = 5'd26;
  localparam logic [4:0] InfoEightBytes = 5'd27;

endpackage

FILE: hdl/cbe_front.sv
module cbe_front import cbe_pkg::*; (
  input  in_item_t  item_i,
  output entry_t    entry_o
);

  logic [2:0]  mt;
  logic [63:0] v;

  always_comb begin
    mt = item_i.major_type;
    v  = item_i.argument;
    if (item_i.mode == ModeSigned) begin
      if (item_i.argument[63]) begin
        mt = MajorNegative;
        v  = ~item_i.argument;
      end else begin
        mt = MajorUnsigned;
      end
    end
  end

  always_comb begin
    entry_o          = '0;
    entry_o.arg      = v;
    unique case (item_i.mode)
      ModeHead, ModeSigned: begin
        if (v[63:5] == '0 && v[4:3] != 2'b11) begin
          entry_o.first_byte = {mt, v[4:0]};
          entry_o.nbytes     = 4'd0;
        end else if (v[63:8] == '0) begin
          entry_o.first_byte = {mt, InfoOneByte};
          entry_o.nbytes     = 4'd1;
        end else if (v[63:16] == '0) begin
          entry_o.first_byte = {mt, InfoTwoBytes};
          entry_o.nbytes     = 4'd2;
        end else if (v[63:32] == '0) begin
          entry_o.first_byte = {mt, InfoFourBytes};
          entry_o.nbytes     = 4'd4;
        end else begin
          entry_o.first_byte = {mt, InfoEightBytes};
          entry_o.nbytes     = 4'd8;
        end
      end
      ModePayload: begin
        entry_o.first_byte = item_i.payload_byte;
        entry_o.nbytes     = 4'd0;
      end
      ModeClear: begin
        entry_o.is_clear = 1'b1;
      end
      default: begin
        entry_o.is_clear = 1'b1;
      end
    endcase
  end

endmodule

FILE: hdl/cbe_queue.sv
`include "cbor_head_encoder_top_defines.svh"

module cbe_queue import cbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  entry_t    push_data_i,
  input  logic      pop_i,
  output entry_t    head_o,
  output q_status_t status_o
);

  entry_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   do_push, do_pop;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (QueuePtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (QueuePtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `CBE_ASSERT(a_count_bound, count_q <= (QueuePtrW+1)'(QueueDepth), "queue count above depth")
  `CBE_ASSERT(a_pop_nonempty, !(pop_i && status_o.empty), "pop from empty queue")

endmodule

FILE: hdl/cbe_back.sv
`include "cbor_head_encoder_top_defines.svh"

module cbe_back import cbe_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  entry_t    head_i,
  input  q_status_t status_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [15:0] cap_q;
  logic [15:0] bw_q, bw_d;
  logic [3:0]  idx_q, idx_d;
  logic        out_valid_q;
  out_item_t   out_q;

  logic        advance, clear_go, emit, is_last, ovf;
  logic [3:0]  byte_sel;
  logic [7:0]  cur_byte;

  assign advance  = !status_i.empty && (!out_valid_q || !out_stall_i);
  assign clear_go = advance && head_i.is_clear;
  assign emit     = advance && !head_i.is_clear;
  assign is_last  = (idx_q == head_i.nbytes);
  assign pop_o    = clear_go || (emit && is_last);
  assign ovf      = !(bw_q < cap_q);
  assign byte_sel = head_i.nbytes - idx_q;
  assign cur_byte = (idx_q == '0) ? head_i.first_byte
                                  : head_i.arg[{byte_sel[2:0], 3'b000} +: 8];

  always_comb begin
    idx_d = idx_q;
    bw_d  = bw_q;
    if (pop_o) begin
      idx_d = '0;
    end else if (emit) begin
      idx_d = idx_q + 4'd1;
    end
    if (clear_go) begin
      bw_d = '0;
    end else if (emit && !ovf) begin
      bw_d = bw_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapacityReset;
      bw_q        <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      bw_q  <= bw_d;
      idx_q <= idx_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte      <= cur_byte;
      out_q.byte_position <= bw_q;
      out_q.overflow      <= ovf;
      out_q.last          <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CBE_ASSERT_NEXT(a_bw_step, emit && !ovf, bw_q == $past(bw_q) + 16'd1, "count did not step")
  `CBE_ASSERT(a_idx_bound, status_i.empty || idx_q <= head_i.nbytes, "byte index past head")
  `CBE_ASSERT(a_idx_idle, !status_i.empty || idx_q == '0, "byte index set while queue empty")

endmodule

FILE: hdl/cbor_head_encoder_top.sv
// CBOR head encoder.
// Input channel: in_valid_i, in_stall_o and in_data_i carry one item per beat:
// a head with major type, a signed integer, one raw payload byte or a clear.
// Output channel: out_valid_o, out_stall_i and out_data_o carry one encoded
// byte per beat, with its buffer offset, an overflow flag and a last flag.
// Each head item gives 1, 2, 3, 5 or 9 output beats, a payload item one beat
// and a clear none; a clear uses the emitter only to reset the byte count.
// When the queue is empty, an input beat is first written into a queue entry
// and then registered as the first output beat, which the receiver takes. A
// four-entry queue sits between the classifier and the emitter, so new items
// are taken while bytes of earlier ones still go out.
// The capacity register is written through cfg_we_i and cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not enforce.
// Reset empties the queue, clears the byte count and sets the capacity to 256.
// When the receiver stalls, the output beat holds; once the queue fills,
// in_stall_o rises until the emitter frees an entry.
module cbor_head_encoder_top import cbe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  entry_t    front_entry;
  entry_t    head_entry;
  q_status_t q_status;
  logic      pop;

  cbe_front u_front (
    .item_i  (in_data_i),
    .entry_o (front_entry)
  );

  cbe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_entry),
    .pop_i       (pop),
    .head_o      (head_entry),
    .status_o    (q_status)
  );

  assign in_stall_o = q_status.full;

  cbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head_entry),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
